@@ design/aes_pkg.sv @@
// Shared types, S-box and GF(2^8) helpers for the AES-128 encryption unit.
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [127:0] block_t;
  typedef logic [3:0]   round_t;

  // Word handed from one round cell to the next.
  typedef struct packed {
    logic   vld;
    round_t rnd;
    block_t state;
    block_t rkey;
  } cell_word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] GfReduce = 8'h1b;
  localparam logic [7:0] RconFirst = 8'h01;

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    gf_double = {x[6:0], 1'b0} ^ (x[7] ? GfReduce : 8'h00);
  endfunction

  // Round constant for the key of round r (1..10), doubled from 0x01 up to 0x36.
  function automatic logic [7:0] rcon(input round_t r);
    logic [7:0] v;
    v = RconFirst;
    for (int i = 2; i <= NumRounds; i++) begin
      if (round_t'(i) <= r) v = gf_double(v);
    end
    rcon = v;
  endfunction

endpackage

@@ design/aes_round_cell.sv @@
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey, next round key.
module aes_round_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  aes_pkg::cell_word_t word_i,
  output aes_pkg::cell_word_t word_o
);

  aes_pkg::cell_word_t word_r;
  aes_pkg::cell_word_t word_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [31:0]  kw [4];
  logic [31:0]  nk [4];
  logic [31:0]  tw;
  logic [127:0] key_nxt;
  logic [127:0] mixed;
  aes_pkg::round_t rnd;

  assign rnd = word_i.rnd + 4'd1;

  // Round key for this round from the previous one.
  always_comb begin
    for (int c = 0; c < 4; c++) kw[c] = word_i.rkey[127-32*c -: 32];
    tw = {aes_pkg::SBOX[kw[3][23:16]], aes_pkg::SBOX[kw[3][15:8]],
          aes_pkg::SBOX[kw[3][7:0]], aes_pkg::SBOX[kw[3][31:24]]}
         ^ {aes_pkg::rcon(rnd), 24'h0};
    nk[0] = kw[0] ^ tw;
    nk[1] = kw[1] ^ nk[0];
    nk[2] = kw[2] ^ nk[1];
    nk[3] = kw[3] ^ nk[2];
    key_nxt = {nk[0], nk[1], nk[2], nk[3]};
  end

  // Byte i of the block sits at bits 127-8i; column c holds bytes 4c..4c+3.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = aes_pkg::SBOX[word_i.state[127-8*(((c+r)%4)*4+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] h;
      h = sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3];
      for (int r = 0; r < 4; r++) begin
        mx[c*4+r] = sb[c*4+r] ^ aes_pkg::gf_double(sb[c*4+r] ^ sb[c*4+((r+1)%4)]) ^ h;
      end
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127-8*i -: 8] = (rnd == aes_pkg::round_t'(aes_pkg::NumRounds)) ? sb[i] : mx[i];
    end
  end

  always_comb begin
    word_nxt.vld   = word_i.vld;
    word_nxt.rnd   = rnd;
    word_nxt.state = mixed ^ key_nxt;
    word_nxt.rkey  = key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r.vld <= word_nxt.vld;
    end
    word_r.rnd   <= word_nxt.rnd;
    word_r.state <= word_nxt.state;
    word_r.rkey  <= word_nxt.rkey;
  end

  assign word_o = word_r;

endmodule

@@ design/aes128_block_encrypt_unit.sv @@
// Top level: key registers, initial AddRoundKey and a chain of ten round cells.
//
//  channel | ports                                  | handshake
//  input   | in_plain_high, in_plain_low            | start & !busy
//  result  | out_cipher_high, out_cipher_low        | out_valid, one cycle
//  config  | cfg_we, cfg_index, cfg_wdata           | cfg_we
//
// A block enters every cycle; its ciphertext shows after one input register
// and then the registers of the ten round cells.
// busy is always low: the chain never stalls and the receiver cannot stall.
// Synchronous reset clears the key registers and all valid bits.
module aes128_block_encrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  logic        cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  aes_pkg::cell_word_t head_r;
  aes_pkg::cell_word_t head_nxt;
  aes_pkg::cell_word_t link [aes_pkg::NumRounds+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        aes_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    head_nxt.vld   = start;
    head_nxt.rnd   = '0;
    head_nxt.rkey  = {key_high_r, key_low_r};
    head_nxt.state = {in_plain_high, in_plain_low} ^ {key_high_r, key_low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= head_nxt.vld;
    end
    head_r.rnd   <= head_nxt.rnd;
    head_r.state <= head_nxt.state;
    head_r.rkey  <= head_nxt.rkey;
  end

  assign link[0] = head_r;

  for (genvar g = 0; g < aes_pkg::NumRounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .word_i(link[g]),
      .word_o(link[g+1])
    );
  end

  assign out_valid       = link[aes_pkg::NumRounds].vld;
  assign out_cipher_high = link[aes_pkg::NumRounds].state[127:64];
  assign out_cipher_low  = link[aes_pkg::NumRounds].state[63:0];

endmodule

@@ design/aes_checker.sv @@
// Port-level checks for the AES-128 encryption unit, bound to the top level.
module aes_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##11 out_valid)
    else $error("result missing 11 cycles after start");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 11)) |-> $past(start && !busy, 11))
    else $error("result without a word accepted");

endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

@@ sim/tb_top.sv @@
// Testbench for the AES-128 block encryption unit: directed vectors plus random blocks and keys.
`timescale 1ns / 1ps
module tb_top;

  localparam int ClkPeriod    = 20;
  localparam int Latency      = 11;
  localparam int WatchdogMax  = 2000;
  localparam int NumRandom    = 900;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_plain_high;
  logic [63:0] in_plain_low;
  logic        out_valid;
  logic [63:0] out_cipher_high;
  logic [63:0] out_cipher_low;
  logic        cfg_we;
  logic [aes_pkg::CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  aes128_block_encrypt_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_plain_high   (in_plain_high),
    .in_plain_low    (in_plain_low),
    .out_valid       (out_valid),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  typedef struct {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    logic        known;
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
  } vec_t;

  logic [63:0] key_hi_q, key_lo_q;
  logic [127:0] cipher_fifo[$];
  int errors, blocks_sent, blocks_checked, idle_cycles, key_loads;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
            aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
  endfunction

  // AES-128 encrypt; state byte i lives at blk[127-8*i -: 8].
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                               input logic [127:0] blk);
    logic [31:0] w[44];
    logic [7:0]  s[16];
    logic [7:0]  t[16];
    logic [7:0]  rc, a0, a1, a2, a3, h;
    logic [31:0] tmp;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      tmp = w[i-1];
      if (i % 4 == 0) begin
        tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ tmp;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[c*4+r] = aes_pkg::SBOX[s[((c+r)%4)*4+r]];
        s = t;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
            h = a0 ^ a1 ^ a2 ^ a3;
            s[c*4]   = a0 ^ xtime(a0 ^ a1) ^ h;
            s[c*4+1] = a1 ^ xtime(a1 ^ a2) ^ h;
            s[c*4+2] = a2 ^ xtime(a2 ^ a3) ^ h;
            s[c*4+3] = a3 ^ xtime(a3 ^ a0) ^ h;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[c*4+r] ^= w[rnd*4+c][31-8*r -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Half the time no gap, otherwise mostly a short one, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic write_key_reg(input aes_pkg::cfg_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == aes_pkg::REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    key_loads++;
  endtask

  // Wait until the pipe has drained.
  task automatic drain_pipe();
    while (cipher_fifo.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input int gap);
    logic [127:0] ct;
    ct = aes_encrypt({key_hi_q, key_lo_q}, {hi, lo});
    start         <= 1'b1;
    in_plain_high <= hi;
    in_plain_low  <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_fifo.push_back(ct);
    blocks_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    drain_pipe();
    write_key_reg(aes_pkg::REG_KEY_HIGH, hi);
    write_key_reg(aes_pkg::REG_KEY_LOW, lo);
  endtask

  // Result checker: the receiver cannot stall, so sample on every edge.
  always @(posedge clk) begin
    logic [127:0] exp_ct;
    if (rst_n && out_valid) begin
      if (cipher_fifo.size() == 0) begin
        $display("%0t: unexpected word hi=%h lo=%h", $time, out_cipher_high, out_cipher_low);
        errors++;
      end else begin
        exp_ct = cipher_fifo.pop_front();
        if (out_cipher_high !== exp_ct[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h",
                   $time, exp_ct[127:64], out_cipher_high);
          errors++;
        end
        if (out_cipher_low !== exp_ct[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h",
                   $time, exp_ct[63:0], out_cipher_low);
          errors++;
        end
        blocks_checked++;
      end
    end
  end

  // Watchdog: count cycles without an accepted word on either side or a key register write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogMax) begin
      $display("%0t: watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  vec_t dir_vecs[$];

  initial begin
    vec_t v;
    logic [63:0] kh, kl;
    errors = 0; blocks_sent = 0; blocks_checked = 0; key_loads = 0;
    key_hi_q = '0; key_lo_q = '0;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = aes_pkg::REG_KEY_HIGH;
    cfg_wdata = '0; in_plain_high = '0; in_plain_low = '0;

    // Vectors with known answers, plus key/data extremes checked by the predictor.
    dir_vecs.push_back('{64'h0, 64'h0, 64'h0, 64'h0, 1'b1,
                         64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    dir_vecs.push_back('{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                         64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                         64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    dir_vecs.push_back('{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                         64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1,
                         64'h3925841d02dc09fb, 64'hdc118597196a0b32});
    dir_vecs.push_back('{64'h0, 64'h0, '1, '1, 1'b0, '0, '0});
    dir_vecs.push_back('{'1, '1, 64'h0, 64'h0, 1'b0, '0, '0});
    dir_vecs.push_back('{'1, '1, '1, '1, 1'b0, '0, '0});
    dir_vecs.push_back('{'1, 64'h0, 64'h8000000000000000, 64'h1, 1'b0, '0, '0});
    dir_vecs.push_back('{64'h0, '1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0});
    dir_vecs.push_back('{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                         64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key is all zero: first block goes out before any key write.
    send_block(64'h0, 64'h0, 0);
    start <= 1'b0;

    foreach (dir_vecs[i]) begin
      v = dir_vecs[i];
      set_key(v.key_hi, v.key_lo);
      if (v.known) begin
        if (aes_encrypt({v.key_hi, v.key_lo}, {v.pt_hi, v.pt_lo}) !== {v.ct_hi, v.ct_lo}) begin
          $display("%0t: known-answer predictor expected %h%h actual %h", $time, v.ct_hi,
                   v.ct_lo, aes_encrypt({v.key_hi, v.key_lo}, {v.pt_hi, v.pt_lo}));
          errors++;
        end
      end
      send_block(v.pt_hi, v.pt_lo, 0);
      send_block(rand64(), rand64(), pick_gap());
      start <= 1'b0;
    end

    // Random phase: key changes between bursts of back-to-back or gapped blocks.
    for (int n = 0; n < NumRandom; ) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: begin kh = '0; kl = '1; end
          1: begin kh = '1; kl = rand64(); end
          default: begin kh = rand64(); kl = rand64(); end
        endcase
        set_key(kh, kl);
      end
      if ($urandom_range(0, 3) == 0) begin
        // Stretch with no idling.
        repeat ($urandom_range(5, 25)) begin
          send_block(rand64(), rand64(), 0);
          n++;
        end
      end else begin
        send_block(rand64(), rand64(), pick_gap());
        n++;
      end
      if (n % 60 == 0) start <= 1'b0;
    end
    start <= 1'b0;

    while (cipher_fifo.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);

    $display("Encrypted %0d blocks (%0d checked) across %0d key register writes,",
             blocks_sent, blocks_checked, key_loads);
    $display("including all-zero, all-one and standard known-answer keys and blocks.");
    if (errors == 0 && cipher_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
